### rtl/ush_pkg.sv
package ush_pkg;

    localparam int HASH_W = 24;
    localparam int SIZE_W = 25;
    localparam int BYTE_W = 8;
    localparam int PROD_W = 2 * HASH_W;
    localparam int CNT_W  = $clog2(PROD_W);

    localparam logic [HASH_W-1:0] MULT_START = 24'd31415;
    localparam logic [HASH_W-1:0] MULT_STEP  = 24'd27183;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 25'd1024;
    localparam logic [SIZE_W-1:0] SIZE_MIN   = 25'd2;
    localparam logic [SIZE_W-1:0] SIZE_MAX   = 25'd16777216;

    localparam logic [CNT_W-1:0]  CNT_LAST   = CNT_W'(PROD_W - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD_H,
        ST_MOD_H,
        ST_MOD_M
    } state_t;

    typedef struct packed {
        logic                start;
        logic [PROD_W-1:0]   dividend;
        logic [SIZE_W-1:0]   divisor;
    } mod_req_t;

endpackage

### rtl/ush_mul.sv
module ush_mul
(
    input  logic                         clk,
    input  logic                         en,
    input  logic [ush_pkg::HASH_W-1:0]   a,
    input  logic [ush_pkg::HASH_W-1:0]   b,
    output logic [ush_pkg::PROD_W-1:0]   product
);

    logic [ush_pkg::PROD_W-1:0] product_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            product_reg <= ush_pkg::PROD_W'(a) * ush_pkg::PROD_W'(b);
        end
    end

    assign product = product_reg;

endmodule

### rtl/ush_mod.sv
// Restoring remainder, one dividend bit per cycle, MSB first.
module ush_mod
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  ush_pkg::mod_req_t            req,
    output logic                         done,
    output logic [ush_pkg::HASH_W-1:0]   remainder
);

    logic                         busy_reg;
    logic                         done_reg;
    logic [ush_pkg::CNT_W-1:0]    cnt_reg;
    logic [ush_pkg::PROD_W-1:0]   div_sr_reg;
    logic [ush_pkg::SIZE_W-1:0]   divisor_reg;
    logic [ush_pkg::HASH_W-1:0]   rem_reg;
    logic [ush_pkg::HASH_W-1:0]   rem_next;
    logic [ush_pkg::SIZE_W-1:0]   trial;

    always_comb
    begin
        trial = {rem_reg, div_sr_reg[ush_pkg::PROD_W-1]};
        if (trial >= divisor_reg)
        begin
            rem_next = ush_pkg::HASH_W'(trial - divisor_reg);
        end
        else
        begin
            rem_next = ush_pkg::HASH_W'(trial);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == ush_pkg::CNT_LAST)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            div_sr_reg  <= req.dividend;
            divisor_reg <= req.divisor;
            rem_reg     <= '0;
        end
        else if (busy_reg)
        begin
            div_sr_reg <= {div_sr_reg[ush_pkg::PROD_W-2:0], 1'b0};
            rem_reg    <= rem_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

### rtl/universal_string_hash_top.sv
// Universal string hash: bytes arrive one per request on in_valid/in_ready;
// a zero byte ends the string and returns its hash on out_valid/out_ready,
// then the hash and multiplier restart (empty string hashes to 0). While
// a nonzero byte is hashed, in_ready stays low: one shared 24x24
// multiplier and one bit-serial remainder unit (a load and 48 shifts per
// reduction) handle first mult*hash+byte mod table_size, then
// mult*27183 mod (table_size-1). A zero byte needs no multiply or
// reduction. table_size (cfg_we/cfg_wdata, reset 1024) is clamped to
// 2..16777216 and may be written only while the block is idle.
module universal_string_hash_top
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [ush_pkg::SIZE_W-1:0]   cfg_wdata,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [ush_pkg::BYTE_W-1:0]   text_byte,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [ush_pkg::HASH_W-1:0]   hash_value
);

    ush_pkg::state_t               state_reg;
    ush_pkg::state_t               state_next;
    logic [ush_pkg::SIZE_W-1:0]    size_reg;
    logic [ush_pkg::SIZE_W-1:0]    size_eff;
    logic [ush_pkg::SIZE_W-1:0]    mod_m;
    logic [ush_pkg::HASH_W-1:0]    hash_reg;
    logic [ush_pkg::HASH_W-1:0]    mult_reg;
    logic [ush_pkg::BYTE_W-1:0]    byte_reg;
    logic                          out_valid_reg;
    logic [ush_pkg::HASH_W-1:0]    hash_value_reg;

    logic                          accept;
    logic                          mul_en;
    logic [ush_pkg::HASH_W-1:0]    mul_b;
    logic [ush_pkg::PROD_W-1:0]    product;
    ush_pkg::mod_req_t             mod_req;
    logic                          rem_done;
    logic [ush_pkg::HASH_W-1:0]    remainder;

    always_comb
    begin
        if (size_reg < ush_pkg::SIZE_MIN)
        begin
            size_eff = ush_pkg::SIZE_MIN;
        end
        else if (size_reg > ush_pkg::SIZE_MAX)
        begin
            size_eff = ush_pkg::SIZE_MAX;
        end
        else
        begin
            size_eff = size_reg;
        end
        mod_m = size_eff - 1'b1;
    end

    assign in_ready = (state_reg == ush_pkg::ST_IDLE) && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next       = state_reg;
        mul_en           = 1'b0;
        mul_b            = hash_reg;
        mod_req.start    = 1'b0;
        mod_req.dividend = product + ush_pkg::PROD_W'(byte_reg);
        mod_req.divisor  = size_eff;
        case (state_reg)
            ush_pkg::ST_IDLE:
            begin
                if (accept && (text_byte != '0))
                begin
                    mul_en     = 1'b1;
                    state_next = ush_pkg::ST_LOAD_H;
                end
            end
            ush_pkg::ST_LOAD_H:
            begin
                mod_req.start = 1'b1;
                mul_en        = 1'b1;
                mul_b         = ush_pkg::MULT_STEP;
                state_next    = ush_pkg::ST_MOD_H;
            end
            ush_pkg::ST_MOD_H:
            begin
                if (rem_done)
                begin
                    mod_req.start    = 1'b1;
                    mod_req.dividend = product;
                    mod_req.divisor  = mod_m;
                    state_next       = ush_pkg::ST_MOD_M;
                end
            end
            ush_pkg::ST_MOD_M:
            begin
                if (rem_done)
                begin
                    state_next = ush_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ush_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ush_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg      <= ush_pkg::SIZE_RESET;
            hash_reg      <= '0;
            mult_reg      <= ush_pkg::MULT_START;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                size_reg <= cfg_wdata;
            end
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (accept && (text_byte == '0))
            begin
                out_valid_reg <= 1'b1;
                hash_reg      <= '0;
                mult_reg      <= ush_pkg::MULT_START;
            end
            if ((state_reg == ush_pkg::ST_MOD_H) && rem_done)
            begin
                hash_reg <= remainder;
            end
            if ((state_reg == ush_pkg::ST_MOD_M) && rem_done)
            begin
                mult_reg <= remainder;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= text_byte;
            if (text_byte == '0)
            begin
                hash_value_reg <= hash_reg;
            end
        end
    end

    ush_mul u_mul
    (
        .clk     (clk),
        .en      (mul_en),
        .a       (mult_reg),
        .b       (mul_b),
        .product (product)
    );

    ush_mod u_mod
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (mod_req),
        .done      (rem_done),
        .remainder (remainder)
    );

    assign out_valid  = out_valid_reg;
    assign hash_value = hash_value_reg;

    a_busy_after_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (text_byte != '0)) |=> !in_ready)
        else $error("in_ready high while a byte is being hashed");

    a_result_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (text_byte == '0)) |=>
            (out_valid && (hash_value == $past(hash_reg)) && (hash_reg == '0)))
        else $error("string end did not produce hash or reset state");

    a_done_in_mod: assert property (@(posedge clk) disable iff (!rst_n)
        rem_done |-> ((state_reg == ush_pkg::ST_MOD_H) || (state_reg == ush_pkg::ST_MOD_M)))
        else $error("remainder done outside a reduction step");

endmodule
